@@ hdl/tccw_pkg.sv @@
// Shared types and constants of the text console cell writer.
// Used by the channel interfaces, the sequencer, the adder unit and the top level.
package tccw_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_CELLS    = 4096;

  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 12;
  localparam int POS_W      = 12;
  localparam int ATTR_W     = 8;
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 6;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CELL_W     = ATTR_W + CHAR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE    = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE      = 8'h20;
  localparam logic [ATTR_W-1:0]  RESET_ATTR = 8'h0F;

  localparam logic [COLS_W-1:0]  RST_COLUMNS = 8'd80;
  localparam logic [ROWS_W-1:0]  RST_ROWS    = 6'd25;
  localparam logic [COLOR_W-1:0] RST_FG      = 4'hF;
  localparam logic [COLOR_W-1:0] RST_BG      = 4'h0;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_READ  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_FG      = 2'd2,
    CFG_BG      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_GEOM_MUL,
    ST_GEOM_FIT,
    ST_GEOM_LAST,
    ST_ROW,
    ST_PUT,
    ST_COPY,
    ST_FILL,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
    logic              scrolled;
  } result_t;

endpackage

@@ hdl/tccw_if.sv @@
// Request and result channel interfaces of the text console cell writer.
// Depends on tccw_pkg for the field widths.
interface tccw_cmd_if;
  import tccw_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, output func, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input func, input char_code, input cell_index,
                  output ready);
endinterface

interface tccw_rsp_if;
  import tccw_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attr;
  logic              scrolled;

  modport source (output valid, output cursor_pos, output read_char, output read_attr,
                  output scrolled, input ready);
  modport sink   (input valid, input cursor_pos, input read_char, input read_attr,
                  input scrolled, output ready);
endinterface

@@ hdl/tccw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tccw_alu.sv @@
// Shared add/subtract unit of the console sequencer.
// Depends on tccw_pkg for the operation codes.
module tccw_alu #(
  parameter int W = 16
) (
  input  tccw_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      sum
);
  import tccw_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: sum = a + b;
      ALU_SUB: sum = a - b;
    endcase
  end

endmodule

@@ hdl/tccw_seq.sv @@
// Sequencer of the text console cell writer: config registers, screen geometry,
// cursor tracking, scroll copy and fill sweeps. Uses tccw_pkg, tccw_if and tccw_alu.
module tccw_seq #(
  parameter int MAX_COLS = tccw_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tccw_pkg::DEF_MAX_ROWS,
  parameter int CELLS    = tccw_pkg::DEF_CELLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tccw_pkg::cfg_wr_t            cfg,
  tccw_cmd_if.sink                     cmd,
  input  logic                         res_free,
  output logic                         res_load,
  output tccw_pkg::result_t            res_d,
  output logic                         mem_we,
  output logic [$clog2(CELLS)-1:0]     mem_waddr,
  output logic [tccw_pkg::CELL_W-1:0]  mem_wdata,
  output logic [$clog2(CELLS)-1:0]     mem_raddr,
  input  logic [tccw_pkg::CELL_W-1:0]  mem_rdata
);
  import tccw_pkg::*;

  localparam int COLS_LIM = (MAX_COLS < CELLS) ? MAX_COLS : CELLS;
  localparam int CW  = $clog2(COLS_LIM + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int KW  = (CW > COLS_W) ? CW : COLS_W;
  localparam int QW  = (RW > ROWS_W) ? RW : ROWS_W;
  localparam int PW  = CW + RW;
  localparam int AW  = $clog2(CELLS);
  localparam int NW  = $clog2(CELLS + 1);
  localparam int DW  = (PW > NW) ? PW : NW;
  localparam int IXW = (NW > INDEX_W) ? NW : INDEX_W;

  // config registers
  logic [COLS_W-1:0]  columns;
  logic [ROWS_W-1:0]  rows;
  logic [COLOR_W-1:0] fg_nib;
  logic [COLOR_W-1:0] bg_nib;

  state_t            state, state_next;
  logic              dirty, dirty_next;
  logic [AW-1:0]     cursor, cursor_next;
  logic [AW-1:0]     row_base, row_base_next;
  logic [AW-1:0]     last_base, last_base_next;
  logic [CW-1:0]     cols, cols_next;
  logic [DW-1:0]     area, area_next;
  logic [AW-1:0]     fill_i, fill_i_next;
  logic [NW-1:0]     fill_end, fill_end_next;
  logic [CELL_W-1:0] fill_data, fill_data_next;
  logic [AW-1:0]     cp_rd, cp_rd_next;
  logic              pend_v, pend_v_next;
  logic [AW-1:0]     pend_addr, pend_addr_next;
  logic [CHAR_W-1:0] char_q, char_q_next;
  logic              idx_ok, idx_ok_next;
  logic              scrolled, scrolled_next;
  logic [CHAR_W-1:0] rd_char, rd_char_next;
  logic [ATTR_W-1:0] rd_attr, rd_attr_next;

  alu_op_t           alu_op;
  logic [DW-1:0]     alu_a;
  logic [DW-1:0]     alu_sum;
  logic [CELL_W-1:0] blank;

  assign blank = {bg_nib, fg_nib, SPACE};

  tccw_alu #(.W(DW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (DW'(cols)),
    .sum (alu_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= RST_COLUMNS;
      rows    <= RST_ROWS;
      fg_nib  <= RST_FG;
      bg_nib  <= RST_BG;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_COLUMNS: columns <= cfg.data[COLS_W-1:0];
        CFG_ROWS:    rows    <= cfg.data[ROWS_W-1:0];
        CFG_FG:      fg_nib  <= cfg.data[COLOR_W-1:0];
        CFG_BG:      bg_nib  <= cfg.data[COLOR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SWEEP;
      dirty    <= 1'b1;
      cursor   <= '0;
      row_base <= '0;
      fill_i   <= '0;
      pend_v   <= 1'b0;
    end else begin
      state    <= state_next;
      dirty    <= dirty_next;
      cursor   <= cursor_next;
      row_base <= row_base_next;
      fill_i   <= fill_i_next;
      pend_v   <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    last_base <= last_base_next;
    cols      <= cols_next;
    area      <= area_next;
    fill_end  <= fill_end_next;
    fill_data <= fill_data_next;
    cp_rd     <= cp_rd_next;
    pend_addr <= pend_addr_next;
    char_q    <= char_q_next;
    idx_ok    <= idx_ok_next;
    scrolled  <= scrolled_next;
    rd_char   <= rd_char_next;
    rd_attr   <= rd_attr_next;
  end

  always_comb begin
    logic [KW-1:0] cols_w;
    logic [QW-1:0] rows_w;
    logic [CW-1:0] cols_c;
    logic [RW-1:0] rows_c;
    logic          oob;
    logic [AW-1:0] pos_eff;
    logic [DW-1:0] c_new;

    state_next     = state;
    dirty_next     = dirty;
    cursor_next    = cursor;
    row_base_next  = row_base;
    last_base_next = last_base;
    cols_next      = cols;
    area_next      = area;
    fill_i_next    = fill_i;
    fill_end_next  = fill_end;
    fill_data_next = fill_data;
    cp_rd_next     = cp_rd;
    pend_v_next    = pend_v;
    pend_addr_next = pend_addr;
    char_q_next    = char_q;
    idx_ok_next    = idx_ok;
    scrolled_next  = scrolled;
    rd_char_next   = rd_char;
    rd_attr_next   = rd_attr;

    cmd.ready = 1'b0;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = fill_i;
    mem_wdata = fill_data;
    mem_raddr = AW'(cmd.cell_index);
    alu_op    = ALU_ADD;
    alu_a     = DW'(row_base);

    cols_w = KW'(columns);
    if (cols_w == '0) cols_w = KW'(1);
    if (cols_w > KW'(COLS_LIM)) cols_w = KW'(COLS_LIM);
    cols_c = CW'(cols_w);
    rows_w = QW'(rows);
    if (rows_w == '0) rows_w = QW'(1);
    if (rows_w > QW'(MAX_ROWS)) rows_w = QW'(MAX_ROWS);
    rows_c = RW'(rows_w);

    oob     = DW'(cursor) >= area;
    pos_eff = oob ? last_base : cursor;
    c_new   = DW'(pos_eff) + DW'(1);

    unique case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, SPACE};
        if (fill_i == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          fill_i_next = fill_i + AW'(1);
        end
      end

      ST_IDLE: begin
        if (dirty) begin
          state_next = ST_GEOM_MUL;
        end else begin
          cmd.ready = !cfg.we;
          if (cmd.valid && !cfg.we) begin
            scrolled_next = 1'b0;
            rd_char_next  = '0;
            rd_attr_next  = '0;
            char_q_next   = cmd.char_code;
            unique case (func_t'(cmd.func))
              FN_PUT: state_next = ST_PUT;
              FN_CLEAR: begin
                fill_i_next    = '0;
                fill_end_next  = NW'(area);
                fill_data_next = blank;
                cursor_next    = '0;
                row_base_next  = '0;
                state_next     = ST_FILL;
              end
              FN_READ: begin
                // read address goes out this cycle, data is back next cycle
                idx_ok_next = IXW'(cmd.cell_index) < IXW'(CELLS);
                state_next  = ST_RD_DATA;
              end
              FN_NONE: state_next = ST_DONE;
            endcase
          end
        end
      end

      ST_GEOM_MUL: begin
        dirty_next = 1'b0;
        cols_next  = cols_c;
        area_next  = DW'(PW'(cols_c) * PW'(rows_c));
        state_next = ST_GEOM_FIT;
      end

      ST_GEOM_FIT: begin
        // drop whole rows until the area fits the store
        alu_op = ALU_SUB;
        alu_a  = area;
        if (area > DW'(CELLS)) begin
          area_next = alu_sum;
        end else begin
          state_next = ST_GEOM_LAST;
        end
      end

      ST_GEOM_LAST: begin
        alu_op         = ALU_SUB;
        alu_a          = area;
        last_base_next = AW'(alu_sum);
        row_base_next  = '0;
        state_next     = ST_ROW;
      end

      ST_ROW: begin
        // step the row start up to the cursor, held at the last row
        if (alu_sum <= DW'(cursor) && row_base < last_base) begin
          row_base_next = AW'(alu_sum);
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_PUT: begin
        if (char_q == NEWLINE) begin
          c_new = alu_sum;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_eff;
          mem_wdata = {bg_nib, fg_nib, char_q};
        end
        if (c_new >= area) begin
          // ran off the screen: scroll up, cursor lands on the last row
          cursor_next   = last_base;
          row_base_next = last_base;
          scrolled_next = 1'b1;
          cp_rd_next    = '0;
          pend_v_next   = 1'b0;
          state_next    = ST_COPY;
        end else begin
          cursor_next = AW'(c_new);
          if (c_new == alu_sum) begin
            row_base_next = AW'(alu_sum);
          end
          state_next = ST_DONE;
        end
      end

      ST_COPY: begin
        alu_a     = DW'(cp_rd);
        mem_we    = pend_v;
        mem_waddr = pend_addr;
        mem_wdata = mem_rdata;
        if (cp_rd < last_base) begin
          mem_raddr      = AW'(alu_sum);
          cp_rd_next     = cp_rd + AW'(1);
          pend_v_next    = 1'b1;
          pend_addr_next = cp_rd;
        end else begin
          pend_v_next = 1'b0;
          if (!pend_v) begin
            fill_i_next    = last_base;
            fill_end_next  = NW'(area);
            fill_data_next = blank;
            state_next     = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if ((NW'(fill_i) + NW'(1)) == fill_end) begin
          state_next = ST_DONE;
        end else begin
          fill_i_next = fill_i + AW'(1);
        end
      end

      ST_RD_DATA: begin
        if (idx_ok) begin
          rd_char_next = mem_rdata[CHAR_W-1:0];
          rd_attr_next = mem_rdata[CELL_W-1:CHAR_W];
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        // hold until the result register is free
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_SWEEP;
    endcase

    if (cfg.we && (cfg.index == CFG_COLUMNS || cfg.index == CFG_ROWS)) begin
      dirty_next = 1'b1;
    end
  end

  assign res_d.cursor_pos = POS_W'(cursor);
  assign res_d.read_char  = rd_char;
  assign res_d.read_attr  = rd_attr;
  assign res_d.scrolled   = scrolled;

endmodule

@@ hdl/text_console_cell_writer.sv @@
// Text console cell writer: top level with the cell store, sequencer and result register.
// Uses tccw_pkg, tccw_if, tccw_ram, tccw_alu and tccw_seq.
//
// Usage:
//   cmd carries one request (func, char_code, cell_index); it is taken when
//   valid and ready are both high. rsp returns exactly one result per request
//   (cursor_pos, read_char, read_attr, scrolled) through an output register.
//   cfg_we/cfg_index/cfg_data write columns, rows and the two color nibbles;
//   write them only while no request is in flight.
// Scroll and geometry:
//   a put that runs off the screen scrolls: the rows are copied up one row
//   and the last row is blank-filled; the copy and blank fill each move one
//   cell a cycle through the store's single write port. After a columns or
//   rows write the geometry is rebuilt.
// Reset:
//   rst (synchronous) restores the register defaults and homes the cursor,
//   then a clearing pass writes every store cell to a space with attribute
//   0x0F, followed by the geometry build, with cmd.ready low.
// Stall:
//   a result waits in the output register while rsp.ready is low; the next
//   request is still taken and is held finished until the register frees.
module text_console_cell_writer #(
  parameter int MAX_COLS = tccw_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tccw_pkg::DEF_MAX_ROWS,
  parameter int CELLS    = tccw_pkg::DEF_CELLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
  tccw_cmd_if.sink                        cmd,
  tccw_rsp_if.source                      rsp
);
  import tccw_pkg::*;

  localparam int AW = $clog2(CELLS);

  cfg_wr_t       cfg_w;
  logic          res_free;
  logic          res_load;
  result_t       res_d;
  result_t       res_q;
  logic          res_valid;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_w.we    = cfg_we;
  assign cfg_w.index = cfg_idx_t'(cfg_index);
  assign cfg_w.data  = cfg_data;

  tccw_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CELLS    (CELLS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_w),
    .cmd       (cmd),
    .res_free  (res_free),
    .res_load  (res_load),
    .res_d     (res_d),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_free = !res_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid      = res_valid;
  assign rsp.cursor_pos = res_q.cursor_pos;
  assign rsp.read_char  = res_q.read_char;
  assign rsp.read_attr  = res_q.read_attr;
  assign rsp.scrolled   = res_q.scrolled;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("request taken while the previous one is still in work");

  a_no_take_on_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !cmd.ready)
    else $error("request taken during a register write");

  a_scroll_no_read: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.scrolled |-> rsp.read_char == '0 && rsp.read_attr == '0)
    else $error("scrolled result carries read data");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> rsp.valid && rsp.cursor_pos == $past(res_d.cursor_pos))
    else $error("loaded result not presented");

endmodule
